### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/ltt_pkg.sv
// ----------------------------------------------------------------------------
// ltt_pkg
// Types and constants shared by the learned transition table modules.
// ----------------------------------------------------------------------------
package ltt_pkg;

  localparam int DATA_W     = 16;
  localparam int TAG_W      = 8;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int CNT_OUT_W  = 5;
  localparam int COUNT_SAT  = 31;

  localparam logic [TAG_W-1:0] TAG_EMPTY  = 8'd0;
  localparam logic [TAG_W-1:0] PAGE_RESET = 8'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_STEP   = 3'd0,
    REQ_LEARN  = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_COUNT  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NONE_DEL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    wr_state;
    logic    wr_last;
    logic    wr_entry;
    logic    clr_entry;
    logic    clr_all;
    logic    done;
    status_e status;
  } ltt_cmd_t;

  // Search results from the datapath to the controller.
  typedef struct packed {
    logic change_nz;
    logic hit;
    logic slot_ok;
    logic any_used;
  } ltt_stat_t;

endpackage

### hdl/ltt_ctrl.sv
// ----------------------------------------------------------------------------
// ltt_ctrl
// Request sequencer: takes a request beat and turns the search results into
// table and state update commands.
// ----------------------------------------------------------------------------
module ltt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ltt_pkg::REQ_W-1:0]     req_type_i,
  input  ltt_pkg::ltt_stat_t            stat_i,
  output ltt_pkg::ltt_cmd_t             cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);

  ltt_pkg::ctrl_state_e          state_q, state_d;
  logic [ltt_pkg::REQ_W-1:0]     req_q;
  logic                          done_q;
  logic                          accept;
  logic                          exec;

  assign accept = start_i && (state_q == ltt_pkg::S_IDLE);
  assign exec   = (state_q == ltt_pkg::S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ltt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ltt_pkg::S_EXEC;
        end
      end
      ltt_pkg::S_EXEC: begin
        state_d = ltt_pkg::S_IDLE;
      end
      default: begin
        state_d = ltt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ltt_pkg::S_IDLE;
      req_q   <= ltt_pkg::REQ_COUNT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (accept) begin
        req_q <= req_type_i;
      end
    end
  end

  // Decide the updates from the request and the search outcome.
  always_comb begin
    cmd_o           = '0;
    cmd_o.status    = ltt_pkg::ST_DONE;
    cmd_o.load      = accept;
    cmd_o.done      = exec;
    if (exec) begin
      case (ltt_pkg::req_e'(req_q))
        ltt_pkg::REQ_STEP: begin
          if (stat_i.change_nz) begin
            cmd_o.wr_last = 1'b1;
            if (stat_i.hit) begin
              cmd_o.wr_state = 1'b1;
            end else begin
              cmd_o.status = ltt_pkg::ST_NOT_FOUND;
            end
          end
        end
        ltt_pkg::REQ_LEARN: begin
          if (stat_i.hit) begin
            cmd_o.status = ltt_pkg::ST_PRESENT;
          end else if (stat_i.slot_ok) begin
            cmd_o.wr_entry = 1'b1;
          end else begin
            cmd_o.status = ltt_pkg::ST_FULL;
          end
        end
        ltt_pkg::REQ_REMOVE: begin
          if (stat_i.hit) begin
            cmd_o.clr_entry = 1'b1;
          end else begin
            cmd_o.status = ltt_pkg::ST_NOT_FOUND;
          end
        end
        ltt_pkg::REQ_CLEAR: begin
          if (stat_i.any_used) begin
            cmd_o.clr_all = 1'b1;
          end else begin
            cmd_o.status = ltt_pkg::ST_NONE_DEL;
          end
        end
        default: begin
          cmd_o.status = ltt_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign busy_o = exec;
  assign done_o = done_q;

endmodule

### hdl/ltt_datapath.sv
// ----------------------------------------------------------------------------
// ltt_datapath
// Transition table storage, parallel match and free-slot search, machine
// state and registered result fields.
// ----------------------------------------------------------------------------
module ltt_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltt_pkg::TAG_W-1:0]        cfg_data_i,
  input  logic [ltt_pkg::DATA_W-1:0]       input_value_i,
  input  logic [ltt_pkg::DATA_W-1:0]       next_state_i,
  input  ltt_pkg::ltt_cmd_t                cmd_i,
  output ltt_pkg::ltt_stat_t               stat_o,
  output logic [ltt_pkg::DATA_W-1:0]       present_state_o,
  output logic [ltt_pkg::STATUS_W-1:0]     status_o,
  output logic [ltt_pkg::CNT_OUT_W-1:0]    entry_count_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EXT_W = (CNT_W > ltt_pkg::CNT_OUT_W) ? CNT_W : ltt_pkg::CNT_OUT_W;

  logic [ltt_pkg::TAG_W-1:0]      page_q;
  logic [ltt_pkg::DATA_W-1:0]     last_q;
  logic [ltt_pkg::DATA_W-1:0]     state_q, state_d;
  logic [ltt_pkg::DATA_W-1:0]     in_q;
  logic [ltt_pkg::DATA_W-1:0]     nxt_q;
  logic [CNT_W-1:0]               count_q, count_d;

  logic [ltt_pkg::TAG_W-1:0]      tag_q    [ENTRIES];
  logic [ltt_pkg::DATA_W-1:0]     masked_q [ENTRIES];
  logic [ltt_pkg::DATA_W-1:0]     from_q   [ENTRIES];
  logic [ltt_pkg::DATA_W-1:0]     mask_q   [ENTRIES];
  logic [ltt_pkg::DATA_W-1:0]     target_q [ENTRIES];

  logic [ltt_pkg::DATA_W-1:0]     present_state_q;
  logic [ltt_pkg::STATUS_W-1:0]   status_q;
  logic [ltt_pkg::CNT_OUT_W-1:0]  entry_count_q;

  logic [ltt_pkg::DATA_W-1:0]     change;
  logic [ltt_pkg::DATA_W-1:0]     masked;
  logic                           page_nz;
  logic [ENTRIES-1:0]             hit_vec;
  logic [ENTRIES-1:0]             free_vec;
  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               free_idx;
  logic [EXT_W-1:0]               count_ext;
  logic [ltt_pkg::CNT_OUT_W-1:0]  count_sat;

  assign change  = last_q ^ in_q;
  assign masked  = change & in_q;
  assign page_nz = (page_q != ltt_pkg::TAG_EMPTY);

  // One comparator per entry; the lowest matching entry wins.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]  = page_nz && (tag_q[i] == page_q) && (masked_q[i] == masked) &&
                    (from_q[i] == state_q) && (mask_q[i] == change);
      free_vec[i] = (tag_q[i] == ltt_pkg::TAG_EMPTY);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign stat_o.change_nz = |change;
  assign stat_o.hit       = |hit_vec;
  assign stat_o.slot_ok   = page_nz && (|free_vec);
  assign stat_o.any_used  = ~(&free_vec);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_all) begin
      count_d = '0;
    end else if (cmd_i.wr_entry) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.clr_entry) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_ext = EXT_W'(count_d);
  assign count_sat = (count_ext > EXT_W'(ltt_pkg::COUNT_SAT)) ?
                     ltt_pkg::CNT_OUT_W'(ltt_pkg::COUNT_SAT) :
                     count_ext[ltt_pkg::CNT_OUT_W-1:0];

  assign state_d = cmd_i.wr_state ? target_q[hit_idx] : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q          <= ltt_pkg::PAGE_RESET;
      last_q          <= '0;
      state_q         <= '0;
      count_q         <= '0;
      present_state_q <= '0;
      status_q        <= '0;
      entry_count_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_q[i] <= ltt_pkg::TAG_EMPTY;
      end
    end else begin
      if (cfg_we_i) begin
        page_q <= cfg_data_i;
      end
      if (cmd_i.wr_last) begin
        last_q <= in_q;
      end
      state_q <= state_d;
      count_q <= count_d;
      if (cmd_i.clr_all) begin
        for (int i = 0; i < ENTRIES; i++) begin
          tag_q[i] <= ltt_pkg::TAG_EMPTY;
        end
      end else if (cmd_i.wr_entry) begin
        tag_q[free_idx] <= page_q;
      end else if (cmd_i.clr_entry) begin
        tag_q[hit_idx] <= ltt_pkg::TAG_EMPTY;
      end
      if (cmd_i.done) begin
        present_state_q <= state_d;
        status_q        <= cmd_i.status;
        entry_count_q   <= count_sat;
      end
    end
  end

  // Request payload and entry data words carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= input_value_i;
      nxt_q <= next_state_i;
    end
    if (cmd_i.wr_entry) begin
      masked_q[free_idx] <= masked;
      from_q[free_idx]   <= state_q;
      mask_q[free_idx]   <= change;
      target_q[free_idx] <= nxt_q;
    end
  end

  assign present_state_o = present_state_q;
  assign status_o        = status_q;
  assign entry_count_o   = entry_count_q;

endmodule

### hdl/learned_transition_table.sv
// ----------------------------------------------------------------------------
// learned_transition_table
// Programmable state machine driven by a learned table of input-change
// transitions, with learn, remove, clear and count requests.
// ----------------------------------------------------------------------------
// A request beat is taken at a rising edge where start_i is high and busy_o
// is low. During the following cycle busy_o is high and the whole table is
// compared in parallel, one comparator per entry with a priority pick of the
// lowest match and the lowest empty slot; the table, the machine state and
// the recorded input are updated at the edge that ends that cycle. The result
// beat then sits on present_state_o, status_o and entry_count_o for exactly
// one cycle, marked by done_o, and the receiver cannot stall it: it must take
// the beat in that cycle. In that same cycle busy_o is already low, so the
// next request may be issued while the previous result is being shown, but
// not while a request is executing. The page register (cfg_we_i, cfg_data_i)
// should only be written while no request is in flight; it resets to page 1,
// and page 0 owns no entries. The table tags reset to empty; entry data words
// have no reset and are only ever read from entries that were written by a
// learn request.
// ----------------------------------------------------------------------------
module learned_transition_table #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltt_pkg::TAG_W-1:0]        cfg_data_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [ltt_pkg::REQ_W-1:0]        req_type_i,
  input  logic [ltt_pkg::DATA_W-1:0]       input_value_i,
  input  logic [ltt_pkg::DATA_W-1:0]       next_state_i,
  output logic                             done_o,
  output logic [ltt_pkg::DATA_W-1:0]       present_state_o,
  output logic [ltt_pkg::STATUS_W-1:0]     status_o,
  output logic [ltt_pkg::CNT_OUT_W-1:0]    entry_count_o
);

  // The controller only sees the summarized search outcome and drives the
  // datapath through a single command bundle.
  ltt_pkg::ltt_cmd_t  cmd;
  ltt_pkg::ltt_stat_t stat;

  ltt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .done_o     (done_o)
  );

  ltt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .input_value_i   (input_value_i),
    .next_state_i    (next_state_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .present_state_o (present_state_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

### hdl/ltt_checker.sv
// ----------------------------------------------------------------------------
// ltt_checker
// Port-level timing checks for the learned transition table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [ltt_pkg::CNT_OUT_W-1:0] entry_count_o
);

  logic accept;

  assign accept = start_i && !busy_o;

  // A taken request occupies exactly one execute cycle, then its result shows.
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy_o)
  `ASSERT_NXT(a_exec_one_cycle, clk_i, rst_ni, busy_o, !busy_o && done_o)
  `ASSERT_IMP(a_done_has_request, clk_i, rst_ni, done_o, $past(accept, 2))
  // The count only moves together with a result beat.
  `ASSERT_IMP(a_count_with_done, clk_i, rst_ni, !$stable(entry_count_o), done_o)

endmodule

bind learned_transition_table ltt_checker u_ltt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .entry_count_o (entry_count_o)
);

### tb/learned_transition_table_test.sv
// ----------------------------------------------------------------------------
// learned_transition_table_test
// Self-checking bench for the learned transition table state machine.
// ----------------------------------------------------------------------------
// A directed opening walks through the corner cases first. It covers the
// empty table, an unchanged input, misses, a duplicate learn, a full table
// and the unused request codes. Random phases follow under several page
// settings, one of them page zero. Most random traffic teaches a transition
// and then steps or removes it, drawing inputs and states from small pools so
// that learned entries are actually hit. The rest is single requests and pure
// noise. A scoreboard class mirrors the table, predicts each result beat
// when its request beat is taken, and compares the result beats in order.
// ----------------------------------------------------------------------------
module learned_transition_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT = 35;
  localparam int CALM_BEATS = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam int INPUT_POOL = 8;
  localparam int STATE_POOL = 4;
  localparam int unsigned FIRST_SPARE_REQ = 5;
  localparam int unsigned LAST_SPARE_REQ = 7;

  // One predicted result beat.
  typedef struct {
    logic [ltt_pkg::DATA_W-1:0]    state;
    ltt_pkg::status_e              status;
    logic [ltt_pkg::CNT_OUT_W-1:0] count;
  } outcome_t;

  // Mirror of the transition table plus the queue of result beats still due.
  class transition_book;
    logic [ltt_pkg::TAG_W-1:0]  page;
    logic [ltt_pkg::TAG_W-1:0]  tag_q[TABLE_DEPTH];
    logic [ltt_pkg::DATA_W-1:0] masked_q[TABLE_DEPTH];
    logic [ltt_pkg::DATA_W-1:0] from_q[TABLE_DEPTH];
    logic [ltt_pkg::DATA_W-1:0] mask_q[TABLE_DEPTH];
    logic [ltt_pkg::DATA_W-1:0] target_q[TABLE_DEPTH];
    logic [ltt_pkg::DATA_W-1:0] last_in;
    logic [ltt_pkg::DATA_W-1:0] cur_state;
    outcome_t                   due_q[$];
    int                         faults;

    function new();
      page = ltt_pkg::PAGE_RESET;
      foreach (tag_q[i]) tag_q[i] = ltt_pkg::TAG_EMPTY;
      last_in = '0;
      cur_state = '0;
      faults = 0;
    endfunction

    function void set_page(logic [ltt_pkg::TAG_W-1:0] pg);
      page = pg;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // First entry of the active page with this key, or -1. Page zero owns
    // nothing, since a zero tag marks an empty slot.
    function int lookup(logic [ltt_pkg::DATA_W-1:0] masked,
                        logic [ltt_pkg::DATA_W-1:0] change);
      if (page == ltt_pkg::TAG_EMPTY) return -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tag_q[i] == page && masked_q[i] == masked &&
            from_q[i] == cur_state && mask_q[i] == change) return i;
      end
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tag_q[i] == ltt_pkg::TAG_EMPTY) return i;
      end
      return -1;
    endfunction

    function logic [ltt_pkg::CNT_OUT_W-1:0] used_entries();
      int n;
      n = 0;
      foreach (tag_q[i]) if (tag_q[i] != ltt_pkg::TAG_EMPTY) n++;
      if (n > ltt_pkg::COUNT_SAT) n = ltt_pkg::COUNT_SAT;
      return ltt_pkg::CNT_OUT_W'(n);
    endfunction

    // Called for every request beat the block takes.
    function void take_request(logic [ltt_pkg::REQ_W-1:0] req,
                               logic [ltt_pkg::DATA_W-1:0] inp,
                               logic [ltt_pkg::DATA_W-1:0] nxt);
      logic [ltt_pkg::DATA_W-1:0] change;
      logic [ltt_pkg::DATA_W-1:0] masked;
      ltt_pkg::status_e           st;
      int                         hit;
      int                         slot;
      outcome_t                   want;
      change = last_in ^ inp;
      masked = change & inp;
      st = ltt_pkg::ST_DONE;
      case (req)
        ltt_pkg::REQ_STEP: begin
          // An unchanged input is a no-op; otherwise the input is recorded
          // whether or not a transition fires.
          if (change != '0) begin
            hit = lookup(masked, change);
            if (hit >= 0) cur_state = target_q[hit];
            else st = ltt_pkg::ST_NOT_FOUND;
            last_in = inp;
          end
        end
        ltt_pkg::REQ_LEARN: begin
          if (lookup(masked, change) >= 0) begin
            st = ltt_pkg::ST_PRESENT;
          end else begin
            st = ltt_pkg::ST_FULL;
            slot = free_slot();
            if (page != ltt_pkg::TAG_EMPTY && slot >= 0) begin
              tag_q[slot] = page;
              masked_q[slot] = masked;
              from_q[slot] = cur_state;
              mask_q[slot] = change;
              target_q[slot] = nxt;
              st = ltt_pkg::ST_DONE;
            end
          end
        end
        ltt_pkg::REQ_REMOVE: begin
          hit = lookup(masked, change);
          if (hit >= 0) tag_q[hit] = ltt_pkg::TAG_EMPTY;
          else st = ltt_pkg::ST_NOT_FOUND;
        end
        ltt_pkg::REQ_CLEAR: begin
          st = ltt_pkg::ST_NONE_DEL;
          foreach (tag_q[i]) begin
            if (tag_q[i] != ltt_pkg::TAG_EMPTY) begin
              tag_q[i] = ltt_pkg::TAG_EMPTY;
              st = ltt_pkg::ST_DONE;
            end
          end
        end
        default: begin
          // Count and the spare codes leave everything alone.
        end
      endcase
      want.state = cur_state;
      want.status = st;
      want.count = used_entries();
      due_q.push_back(want);
    endfunction

    // Called for every result beat; compares it with the oldest prediction.
    function void check_result(logic [ltt_pkg::DATA_W-1:0] ps,
                               logic [ltt_pkg::STATUS_W-1:0] st,
                               logic [ltt_pkg::CNT_OUT_W-1:0] cnt);
      outcome_t want;
      if (due_q.size() == 0) begin
        fault($sformatf("unrequested result beat: state %h status %0d count %0d",
                        ps, st, cnt));
        return;
      end
      want = due_q.pop_front();
      if (ps !== want.state)
        fault($sformatf("present_state expected %h got %h", want.state, ps));
      if (st !== want.status)
        fault($sformatf("status expected %0d got %0d", want.status, st));
      if (cnt !== want.count)
        fault($sformatf("entry_count expected %0d got %0d", want.count, cnt));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ltt_pkg::TAG_W-1:0]     cfg_data_i;
  logic                          start_i;
  logic                          busy_o;
  logic [ltt_pkg::REQ_W-1:0]     req_type_i;
  logic [ltt_pkg::DATA_W-1:0]    input_value_i;
  logic [ltt_pkg::DATA_W-1:0]    next_state_i;
  logic                          done_o;
  logic [ltt_pkg::DATA_W-1:0]    present_state_o;
  logic [ltt_pkg::STATUS_W-1:0]  status_o;
  logic [ltt_pkg::CNT_OUT_W-1:0] entry_count_o;

  transition_book             book;
  logic [ltt_pkg::DATA_W-1:0] input_pool[INPUT_POOL];
  logic [ltt_pkg::DATA_W-1:0] state_pool[STATE_POOL];
  int                         cycles = 0;

  learned_transition_table #(.ENTRIES(TABLE_DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .input_value_i  (input_value_i),
    .next_state_i   (next_state_i),
    .done_o         (done_o),
    .present_state_o(present_state_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both handshakes are observed at the rising edge, where the values seen
  // are the ones that held during the cycle just ending. A result beat can
  // never belong to a request taken at the same edge, so the order of the two
  // calls does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && book != null) begin
      if (done_o) book.check_result(present_state_o, status_o, entry_count_o);
      if (start_i && !busy_o) book.take_request(req_type_i, input_value_i, next_state_i);
    end
  end

  // Presents one request beat and returns at the edge that takes it. The
  // next call may then present a new beat at that same edge, which keeps
  // start_i high for back-to-back traffic.
  task automatic issue(logic [ltt_pkg::REQ_W-1:0] req, logic [ltt_pkg::DATA_W-1:0] inp,
                       logic [ltt_pkg::DATA_W-1:0] nxt);
    start_i <= 1'b1;
    req_type_i <= req;
    input_value_i <= inp;
    next_state_i <= nxt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(int unsigned n);
    start_i <= 1'b0;
    req_type_i <= ltt_pkg::REQ_W'($urandom_range(LAST_SPARE_REQ));
    input_value_i <= ltt_pkg::DATA_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // Random idle gaps start right after a request is taken and overlap its execute phase.
  task automatic maybe_idle(bit calm);
    if (!calm && $urandom_range(99) < IDLE_PCT) pause($urandom_range(1, 4));
  endtask

  // The page register may only change with nothing in flight. Every request
  // yields a result, so an empty queue means the block is idle.
  task automatic write_page(logic [ltt_pkg::TAG_W-1:0] pg);
    start_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= pg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.set_page(pg);
  endtask

  // Small pools make learned keys recur, so steps and removes find entries.
  task automatic refresh_pools();
    foreach (input_pool[i]) input_pool[i] = ltt_pkg::DATA_W'($urandom);
    foreach (state_pool[i]) state_pool[i] = ltt_pkg::DATA_W'($urandom);
    if ($urandom_range(1)) input_pool[0] = '0;
    if ($urandom_range(1)) input_pool[1] = '1;
    if ($urandom_range(1)) state_pool[0] = '0;
  endtask

  task automatic random_items(int unsigned n);
    int unsigned                sent;
    int unsigned                pick;
    bit                         calm;
    logic [ltt_pkg::DATA_W-1:0] iv;
    logic [ltt_pkg::DATA_W-1:0] ns;
    sent = 0;
    while (sent < n) begin
      // One long stretch in each phase runs with no idle cycles at all.
      calm = (sent >= n / 3) && (sent < n / 3 + CALM_BEATS);
      if ($urandom_range(199) == 0) refresh_pools();
      pick = $urandom_range(99);
      iv = input_pool[$urandom_range(INPUT_POOL - 1)];
      ns = $urandom_range(9) == 0 ? ltt_pkg::DATA_W'($urandom)
                                  : state_pool[$urandom_range(STATE_POOL - 1)];
      maybe_idle(calm);
      if (pick < 35) begin
        // Teach a transition from here, then take it.
        issue(ltt_pkg::REQ_LEARN, iv, ns);
        maybe_idle(calm);
        issue(ltt_pkg::REQ_STEP, iv, ltt_pkg::DATA_W'($urandom));
        sent += 2;
      end else if (pick < 55) begin
        issue(ltt_pkg::REQ_STEP, iv, ltt_pkg::DATA_W'($urandom));
        sent++;
      end else if (pick < 65) begin
        // Teach a transition and take it back out again.
        issue(ltt_pkg::REQ_LEARN, iv, ns);
        maybe_idle(calm);
        issue(ltt_pkg::REQ_REMOVE, iv, ltt_pkg::DATA_W'($urandom));
        sent += 2;
      end else if (pick < 72) begin
        issue(ltt_pkg::REQ_REMOVE, iv, ltt_pkg::DATA_W'($urandom));
        sent++;
      end else if (pick < 77) begin
        issue(ltt_pkg::REQ_LEARN, iv, ns);
        sent++;
      end else if (pick < 81) begin
        issue(ltt_pkg::REQ_CLEAR, ltt_pkg::DATA_W'($urandom), ltt_pkg::DATA_W'($urandom));
        sent++;
      end else if (pick < 85) begin
        issue(ltt_pkg::REQ_COUNT, ltt_pkg::DATA_W'($urandom), ltt_pkg::DATA_W'($urandom));
        sent++;
      end else if (pick < 88) begin
        issue(ltt_pkg::REQ_W'($urandom_range(LAST_SPARE_REQ, FIRST_SPARE_REQ)), iv, ns);
        sent++;
      end else begin
        issue(ltt_pkg::REQ_W'($urandom_range(LAST_SPARE_REQ)), ltt_pkg::DATA_W'($urandom),
              ltt_pkg::DATA_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    book = new();
    refresh_pools();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    start_i <= 1'b0;
    req_type_i <= ltt_pkg::REQ_COUNT;
    input_value_i <= '0;
    next_state_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening on the reset page. The empty table comes first, then
    // an unchanged input and a miss.
    issue(ltt_pkg::REQ_COUNT, '0, '0);
    issue(ltt_pkg::REQ_CLEAR, '0, '0);
    issue(ltt_pkg::REQ_STEP, '0, '1);
    issue(ltt_pkg::REQ_STEP, '1, '0);
    // Learn the fall back to zero from state zero, then learn it again.
    issue(ltt_pkg::REQ_LEARN, '0, '1);
    issue(ltt_pkg::REQ_LEARN, '0, 16'h1234);
    // Taking it moves the machine to the all-ones state.
    issue(ltt_pkg::REQ_STEP, '0, '0);
    issue(ltt_pkg::REQ_REMOVE, 16'hA5A5, '0);
    issue(ltt_pkg::REQ_W'(LAST_SPARE_REQ), '1, '1);
    // Fill every remaining slot, then overflow the table.
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      issue(ltt_pkg::REQ_LEARN, ltt_pkg::DATA_W'(i), ltt_pkg::DATA_W'(i));
    end
    issue(ltt_pkg::REQ_LEARN, 16'h8000, '1);
    issue(ltt_pkg::REQ_REMOVE, 16'd3, '0);
    issue(ltt_pkg::REQ_STEP, 16'd3, '0);
    issue(ltt_pkg::REQ_CLEAR, '1, '1);
    issue(ltt_pkg::REQ_COUNT, '1, '1);

    write_page('1);
    random_items(700);

    // Page zero owns no entries: steps miss, learns report a full table and
    // removes find nothing.
    write_page(ltt_pkg::TAG_EMPTY);
    issue(ltt_pkg::REQ_STEP, 16'h0F0F, '0);
    issue(ltt_pkg::REQ_LEARN, 16'hF0F0, '1);
    issue(ltt_pkg::REQ_REMOVE, 16'hF0F0, '0);
    random_items(60);

    write_page(ltt_pkg::PAGE_RESET);
    random_items(600);

    write_page(ltt_pkg::TAG_W'($urandom_range(254, 2)));
    random_items(600);

    // Drain: every prediction must be met, and nothing extra may follow.
    start_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.pending() != 0) book.fault("result beats still outstanding at the end");
    if (book.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### learned_transition_table.f
+incdir+hdl
hdl/ltt_pkg.sv
hdl/ltt_ctrl.sv
hdl/ltt_datapath.sv
hdl/learned_transition_table.sv
hdl/ltt_checker.sv
tb/learned_transition_table_test.sv
